// ----- hw/rtl/pli_pkg.sv -----
package pli_pkg;

    // Field widths of the table and of the configuration port.
    localparam int COORD_W    = 16;
    localparam int COUNT_W    = 6;
    localparam int INDEX_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // The product of two 17-bit differences has a magnitude below 2**32, and the
    // magnitude of an x difference fits 16 bits.
    localparam int PROD_W = 32;
    localparam int DX_W   = 16;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BOUNDS = 2'd1;
    localparam logic [1:0] ST_INDEX  = 2'd2;
    localparam logic [1:0] ST_FLAT   = 2'd3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINT_COUNT  = 3'd0,
        CFG_X_LOW_BOUND  = 3'd1,
        CFG_X_HIGH_BOUND = 3'd2,
        CFG_Y_LOW_BOUND  = 3'd3,
        CFG_Y_HIGH_BOUND = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                       cmd;
        logic [INDEX_W-1:0]         point_index;
        logic signed [COORD_W-1:0]  x_value;
        logic signed [COORD_W-1:0]  y_value;
        logic signed [COORD_W-1:0]  query_key;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0]  value;
        logic [1:0]                 status;
    } t_out;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } t_point;

endpackage

// ----- hw/rtl/pli_div.sv -----
// Unsigned restoring divider, two quotient bits per clock.
module pli_div import pli_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [DX_W-1:0]   i_divisor,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quotient
);

    localparam int STEPS  = PROD_W / 2;
    localparam int STEP_W = $clog2(STEPS);

    logic              r_run, n_run;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [PROD_W-1:0] r_quo, n_quo;
    logic [DX_W-1:0]   r_rem, n_rem;
    logic [DX_W-1:0]   r_div, n_div;

    logic [DX_W:0]     t1, t2, rem1, rem2;
    logic              ge1, ge2;
    logic [PROD_W-1:0] quo1, quo2;

    always_comb begin
        // First bit: shift in the next dividend bit and try the subtraction.
        t1   = {r_rem, r_quo[PROD_W-1]};
        ge1  = (t1 >= {1'b0, r_div});
        rem1 = ge1 ? (t1 - {1'b0, r_div}) : t1;
        quo1 = {r_quo[PROD_W-2:0], ge1};
        // Second bit, from the partial remainder of the first.
        t2   = {rem1[DX_W-1:0], quo1[PROD_W-1]};
        ge2  = (t2 >= {1'b0, r_div});
        rem2 = ge2 ? (t2 - {1'b0, r_div}) : t2;
        quo2 = {quo1[PROD_W-2:0], ge2};
    end

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = STEP_W'(STEPS - 1);
            n_quo = i_dividend;
            n_rem = '0;
            n_div = i_divisor;
        end else if (r_run) begin
            n_quo = quo2;
            n_rem = rem2[DX_W-1:0];
            if (r_cnt == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- hw/rtl/piecewise_linear_table_interpolator.sv -----
// Piecewise-linear lookup table. An item is taken when start is high and busy
// is low, and every item gives exactly one result beat on o_res, flagged by
// o_res_strobe for a single cycle; the receiver cannot stall, so it must take
// each beat in that cycle. A write item (cmd 0) stores one breakpoint when its
// index and values are in range and answers with value zero and a status. A
// query item (cmd 1) walks the table one breakpoint per cycle through the
// registered read port of the point memory until it finds the first x above
// the key or reaches the last active point, passes through a fetch state for
// the right point when the key lies left of the table, then multiplies,
// launches the divide, waits for the two-bit-per-cycle divider and takes its
// quotient. A zero-width segment skips the divide. busy stays high until the
// cycle of the result beat, so the next item can be taken at the edge that
// ends that beat. There is no clearing pass after reset: slots read as garbage
// until written, so the table must be loaded before it is queried.
// Configuration writes are always ready and must only be issued while the
// block is idle.
module piecewise_linear_table_interpolator import pli_pkg::*; #(
    parameter int MAX_POINTS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  t_in                   i_item,
    output logic                  busy,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_res_strobe,
    output t_out                  o_res
);

    // Slot address width, and a width that holds both the count register and
    // MAX_POINTS itself so the two can be compared.
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_WRITE  = 7'b0000010,
        S_SRCH   = 7'b0000100,
        S_FETCH  = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_DSTART = 7'b0100000,
        S_DIV    = 7'b1000000
    } t_state;

    t_state                    r_state, n_state;
    t_in                       r_item, n_item;
    logic [AW-1:0]             r_i, n_i;
    t_point                    r_prev, n_prev;
    logic signed [COORD_W-1:0] r_x0, n_x0, r_y0, n_y0, r_x1, n_x1, r_y1, n_y1;
    logic signed [33:0]        r_prod, n_prod;
    logic signed [16:0]        r_dx, n_dx;
    logic                      r_strobe, n_strobe;
    t_out                      r_res, n_res;

    logic [COUNT_W-1:0]        r_point_count;
    logic signed [COORD_W-1:0] r_x_lo, r_x_hi, r_y_lo, r_y_hi;

    t_point                    r_mem [MAX_POINTS];
    t_point                    r_rd;
    logic [AW-1:0]             rd_addr;
    logic                      mem_we;

    logic [EW-1:0]             pc_ext, n_act;
    logic                      gt, last;
    logic signed [16:0]        dx, dk, dy;
    logic signed [33:0]        prod_abs;
    logic [DX_W-1:0]           dx_mag;
    logic                      div_start, div_done;
    logic [PROD_W-1:0]         div_quo;
    logic [33:0]               q_ext;
    logic signed [33:0]        q_s, sum;

    // Active count: values below two act as two, values above the table size
    // act as the table size.
    always_comb begin
        pc_ext = EW'(r_point_count);
        if (pc_ext < EW'(2)) begin
            n_act = EW'(2);
        end else if (pc_ext > EW'(MAX_POINTS)) begin
            n_act = EW'(MAX_POINTS);
        end else begin
            n_act = pc_ext;
        end
    end

    // Search compare on the entry that the memory returns this cycle.
    assign gt   = (r_rd.x > r_item.query_key);
    assign last = (EW'(r_i) == (n_act - EW'(1)));

    // Segment differences, all as 17-bit signed values.
    assign dx = {r_x1[COORD_W-1], r_x1} - {r_x0[COORD_W-1], r_x0};
    assign dy = {r_y1[COORD_W-1], r_y1} - {r_y0[COORD_W-1], r_y0};
    assign dk = {r_item.query_key[COORD_W-1], r_item.query_key}
              - {r_x0[COORD_W-1], r_x0};

    // The divider works on magnitudes; an x difference never exceeds 16 bits.
    assign prod_abs  = r_prod[33] ? -r_prod : r_prod;
    assign dx_mag    = DX_W'(r_dx[16] ? -r_dx : r_dx);
    assign div_start = (r_state == S_DSTART);

    // Signed quotient rebuilt from the magnitude, added to the left y.
    assign q_ext = {2'b00, div_quo};
    assign q_s   = (r_prod[33] ^ r_dx[16]) ? -signed'(q_ext) : signed'(q_ext);
    assign sum   = q_s + {{18{r_y0[COORD_W-1]}}, r_y0};

    // While searching, the read port runs one entry ahead of the compare. In
    // every other state it points at entry zero, so a new query finds that
    // entry ready in its first search cycle.
    always_comb begin
        if (r_state == S_SRCH) begin
            rd_addr = r_i + AW'(1);
        end else begin
            rd_addr = '0;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_i      = r_i;
        n_prev   = r_prev;
        n_x0     = r_x0;
        n_y0     = r_y0;
        n_x1     = r_x1;
        n_y1     = r_y1;
        n_prod   = r_prod;
        n_dx     = r_dx;
        n_strobe = 1'b0;
        n_res    = r_res;
        mem_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    n_i    = '0;
                    if (i_item.cmd == CMD_WRITE) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_WRITE: begin
                n_res.value = '0;
                if (EW'(r_item.point_index) >= n_act) begin
                    n_res.status = ST_INDEX;
                end else if (r_item.x_value < r_x_lo || r_item.x_value > r_x_hi ||
                             r_item.y_value < r_y_lo || r_item.y_value > r_y_hi) begin
                    n_res.status = ST_BOUNDS;
                end else begin
                    n_res.status = ST_OK;
                    mem_we       = 1'b1;
                end
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_SRCH: begin
                n_prev = r_rd;
                if (gt && r_i == '0) begin
                    // Key left of the table: the right point is entry one,
                    // which the read port fetches next cycle.
                    n_x0    = r_rd.x;
                    n_y0    = r_rd.y;
                    n_state = S_FETCH;
                end else if (gt || last) begin
                    // Inner segment, or key right of the table: the segment is
                    // the previous entry and this one.
                    n_x0    = r_prev.x;
                    n_y0    = r_prev.y;
                    n_x1    = r_rd.x;
                    n_y1    = r_rd.y;
                    n_state = S_MUL;
                end else begin
                    n_i = r_i + AW'(1);
                end
            end
            S_FETCH: begin
                n_x1    = r_rd.x;
                n_y1    = r_rd.y;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (dx == '0) begin
                    n_res.value  = r_y0;
                    n_res.status = ST_FLAT;
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_prod  = dk * dy;
                    n_dx    = dx;
                    n_state = S_DSTART;
                end
            end
            S_DSTART: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    if (sum > 34'sd32767) begin
                        n_res.value = 16'sh7FFF;
                    end else if (sum < -34'sd32768) begin
                        n_res.value = 16'sh8000;
                    end else begin
                        n_res.value = sum[COORD_W-1:0];
                    end
                    n_res.status = ST_OK;
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    pli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_abs[PROD_W-1:0]),
        .i_divisor  (dx_mag),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Breakpoint memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(r_item.point_index)] <= '{x: r_item.x_value, y: r_item.y_value};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_strobe      <= 1'b0;
            r_point_count <= COUNT_W'(2);
            r_x_lo        <= 16'sh8000;
            r_x_hi        <= 16'sh7FFF;
            r_y_lo        <= 16'sh8000;
            r_y_hi        <= 16'sh7FFF;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POINT_COUNT:  r_point_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_X_LOW_BOUND:  r_x_lo        <= i_cfg_data;
                    CFG_X_HIGH_BOUND: r_x_hi        <= i_cfg_data;
                    CFG_Y_LOW_BOUND:  r_y_lo        <= i_cfg_data;
                    CFG_Y_HIGH_BOUND: r_y_hi        <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_item <= n_item;
        r_i    <= n_i;
        r_prev <= n_prev;
        r_x0   <= n_x0;
        r_y0   <= n_y0;
        r_x1   <= n_x1;
        r_y1   <= n_y1;
        r_prod <= n_prod;
        r_dx   <= n_dx;
        r_res  <= n_res;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

`ifndef NO_ASSERTIONS
    // Every item passes through a busy state before its result beat, so result beats never touch.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe)
        else $error("result strobe held for two cycles");

    // A result beat only appears once the sequencer has returned to idle.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> !busy)
        else $error("result beat while still busy");

    // A refused write always reports a zero value.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && (o_res.status == ST_BOUNDS || o_res.status == ST_INDEX))
        |-> (o_res.value == '0))
        else $error("refused write with nonzero value");

    // The divider finishes only while the sequencer waits for it.
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide wait");
`endif

endmodule
